// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppam assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppam assertion failed");

`endif

// ----- src/ppam_pkg.sv -----
// Package for the plot point autoscale mapper: defaults, codes and shared types.
`timescale 1ns / 1ps
package ppam_pkg;

	localparam int POINT_DEPTH_DEF  = 256;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COORD_WIDTH_DEF  = 12;
	localparam int INDEX_WIDTH      = 8;

	localparam int AREA_LEFT_RST   = 0;
	localparam int AREA_TOP_RST    = 0;
	localparam int AREA_RIGHT_RST  = 80;
	localparam int AREA_BOTTOM_RST = 24;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	typedef enum logic [1:0] {
		CFG_AREA_LEFT   = 2'd0,
		CFG_AREA_TOP    = 2'd1,
		CFG_AREA_RIGHT  = 2'd2,
		CFG_AREA_BOTTOM = 2'd3
	} ppam_cfg_idx_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic done;
		logic rem_nz;
	} ppam_div_stat_t;

endpackage

// ----- src/ppam_store.sv -----
// Point store memories, fill count and running extremes of x and y.
`timescale 1ns / 1ps
module ppam_store #(
	parameter int POINT_DEPTH  = ppam_pkg::POINT_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = ppam_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load_en,
	input  logic                                    first,
	input  logic signed [SAMPLE_WIDTH-1:0]          x_in,
	input  logic signed [SAMPLE_WIDTH-1:0]          y_in,
	input  logic                                    rd_en,
	input  logic [ppam_pkg::INDEX_WIDTH-1:0]        rd_addr,
	output logic signed [SAMPLE_WIDTH-1:0]          rd_x,
	output logic signed [SAMPLE_WIDTH-1:0]          rd_y,
	output logic [$clog2(POINT_DEPTH+1)-1:0]        count,
	output logic signed [SAMPLE_WIDTH-1:0]          least_x,
	output logic signed [SAMPLE_WIDTH-1:0]          greatest_x,
	output logic signed [SAMPLE_WIDTH-1:0]          least_y,
	output logic signed [SAMPLE_WIDTH-1:0]          greatest_y
);

	localparam int AW   = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
	localparam int CNTW = $clog2(POINT_DEPTH+1);

	logic signed [SAMPLE_WIDTH-1:0] x_mem [POINT_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] y_mem [POINT_DEPTH];

	logic [CNTW-1:0]                count_q;
	logic signed [SAMPLE_WIDTH-1:0] least_x_q, greatest_x_q, least_y_q, greatest_y_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_x_q, rd_y_q;

	logic          restart, full, wr_en;
	logic [AW-1:0] wr_addr, rd_ix;

	// an empty store restarts the set even without first
	assign restart = load_en && (first || (count_q == '0));
	assign full    = (count_q == CNTW'(POINT_DEPTH));
	assign wr_en   = restart || (load_en && !full);
	assign wr_addr = restart ? '0 : count_q[AW-1:0];
	assign rd_ix   = AW'(rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= x_in;
			y_mem[wr_addr] <= y_in;
		end
		if (rd_en) begin
			rd_x_q <= x_mem[rd_ix];
			rd_y_q <= y_mem[rd_ix];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			least_x_q    <= '0;
			greatest_x_q <= '0;
			least_y_q    <= '0;
			greatest_y_q <= '0;
		end else if (restart) begin
			count_q      <= CNTW'(1);
			least_x_q    <= x_in;
			greatest_x_q <= x_in;
			least_y_q    <= y_in;
			greatest_y_q <= y_in;
		end else if (wr_en) begin
			count_q <= count_q + CNTW'(1);
			if (x_in < least_x_q)    least_x_q    <= x_in;
			if (x_in > greatest_x_q) greatest_x_q <= x_in;
			if (y_in < least_y_q)    least_y_q    <= y_in;
			if (y_in > greatest_y_q) greatest_y_q <= y_in;
		end
	end

	assign rd_x       = rd_x_q;
	assign rd_y       = rd_y_q;
	assign count      = count_q;
	assign least_x    = least_x_q;
	assign greatest_x = greatest_x_q;
	assign least_y    = least_y_q;
	assign greatest_y = greatest_y_q;

endmodule

// ----- src/ppam_div.sv -----
// Serial restoring divider, one quotient bit per cycle, quotient bounded to QW bits.
`timescale 1ns / 1ps
module ppam_div #(
	parameter int SAMPLE_WIDTH = ppam_pkg::SAMPLE_WIDTH_DEF,
	parameter int QW           = ppam_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SAMPLE_WIDTH+QW-1:0]   dividend,
	input  logic [SAMPLE_WIDTH-1:0]      divisor,
	output logic [QW-1:0]                quotient,
	output ppam_pkg::ppam_div_stat_t     stat
);

	localparam int CW = $clog2(QW+1);

	logic [SAMPLE_WIDTH-1:0] rem_q, dsr_q;
	logic [QW-1:0]           lo_q;
	logic [CW-1:0]           cnt_q;
	logic                    done_q;

	logic [SAMPLE_WIDTH:0]   trial, diff;
	logic                    take;

	// caller guarantees dividend < divisor * 2^QW, so the top part starts below divisor
	assign trial = {rem_q, lo_q[QW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SAMPLE_WIDTH+QW-1:QW];
			lo_q  <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= take ? diff[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
			lo_q  <= {lo_q[QW-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(QW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient    = lo_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = (rem_q != '0);

endmodule

// ----- src/plot_point_autoscale_mapper_core.sv -----
// Top level: config registers, sequencer, shared multiplier and output register.
// A load leaves the core idle, so the next item is accepted in the following cycle.
// A map runs through the states MULX, STX, DIVX, MULY, STY, DIVY and FIN, with
// two passes of the shared serial divider at one quotient bit per cycle; the next item
// is accepted once FIN has handed its result on. An unloaded index goes from IDLE to FIN.
// Reset empties the point set, zeroes the extremes and restores the default plot area.
`timescale 1ns / 1ps
module plot_point_autoscale_mapper_core #(
	parameter int POINT_DEPTH  = ppam_pkg::POINT_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = ppam_pkg::SAMPLE_WIDTH_DEF,
	parameter int COORD_WIDTH  = ppam_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [COORD_WIDTH:0]                 cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic                                 first,
	input  logic signed [SAMPLE_WIDTH-1:0]       x_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]       y_sample,
	input  logic [ppam_pkg::INDEX_WIDTH-1:0]     point_index,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [COORD_WIDTH-1:0]               column,
	output logic [COORD_WIDTH-1:0]               row,
	output logic                                 status
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int CW   = COORD_WIDTH;
	localparam int QW   = COORD_WIDTH + 1;
	localparam int PW   = SW + QW;
	localparam int CNTW = $clog2(POINT_DEPTH+1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MULX = 8'b0000_0010,
		S_STX  = 8'b0000_0100,
		S_DIVX = 8'b0000_1000,
		S_MULY = 8'b0001_0000,
		S_STY  = 8'b0010_0000,
		S_DIVY = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CW-1:0] area_left_q, area_top_q;
	logic [CW:0]   area_right_q, area_bottom_q;

	logic in_acc, load_acc, map_acc, bad_index;

	logic signed [SW-1:0] rd_x, rd_y, least_x, greatest_x, least_y, greatest_y;
	logic [CNTW-1:0]      pts_count;

	logic signed [CW+1:0] size_x_full, size_y_full;
	logic [QW-1:0]        size_x, size_y;
	logic [SW-1:0]        diff_x, diff_y, span_x_raw, span_y_raw, span_x, span_y;

	logic [SW-1:0] mul_a;
	logic [QW-1:0] mul_b;
	logic [PW-1:0] prod_d, prod_q;

	logic                     div_start;
	logic [QW-1:0]            quot;
	ppam_pkg::ppam_div_stat_t div_stat;

	logic [CW-1:0] col_q, row_q;
	logic          st_q;
	logic [CW-1:0] column_q, row_out_q;
	logic          status_q, out_valid_q;

	// ---------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q   <= CW'(ppam_pkg::AREA_LEFT_RST);
			area_top_q    <= CW'(ppam_pkg::AREA_TOP_RST);
			area_right_q  <= QW'(ppam_pkg::AREA_RIGHT_RST);
			area_bottom_q <= QW'(ppam_pkg::AREA_BOTTOM_RST);
		end else if (cfg_valid) begin
			case (ppam_pkg::ppam_cfg_idx_t'(cfg_index))
				ppam_pkg::CFG_AREA_LEFT:   area_left_q   <= cfg_data[CW-1:0];
				ppam_pkg::CFG_AREA_TOP:    area_top_q    <= cfg_data[CW-1:0];
				ppam_pkg::CFG_AREA_RIGHT:  area_right_q  <= cfg_data;
				ppam_pkg::CFG_AREA_BOTTOM: area_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input side
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (op == ppam_pkg::OP_LOAD);
	assign map_acc   = in_acc && (op == ppam_pkg::OP_MAP);
	assign bad_index = (32'(point_index) >= 32'(pts_count)) ||
	                   (32'(point_index) >= 32'(POINT_DEPTH));

	ppam_store #(
		.POINT_DEPTH (POINT_DEPTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (load_acc),
		.first     (first),
		.x_in      (x_sample),
		.y_in      (y_sample),
		.rd_en     (map_acc),
		.rd_addr   (point_index),
		.rd_x      (rd_x),
		.rd_y      (rd_y),
		.count     (pts_count),
		.least_x   (least_x),
		.greatest_x(greatest_x),
		.least_y   (least_y),
		.greatest_y(greatest_y)
	);

	// ---------------- axis sizes and spans (negative size clamps to zero)
	assign size_x_full = $signed({1'b0, area_right_q}) - $signed({2'b00, area_left_q})
	                     - (CW+2)'(1);
	assign size_y_full = $signed({1'b0, area_bottom_q}) - $signed({2'b00, area_top_q})
	                     - (CW+2)'(1);
	assign size_x = size_x_full[CW+1] ? '0 : size_x_full[CW:0];
	assign size_y = size_y_full[CW+1] ? '0 : size_y_full[CW:0];

	// differences are never negative, so the SW-bit wrap gives the true value
	assign diff_x     = rd_x - least_x;
	assign diff_y     = rd_y - least_y;
	assign span_x_raw = greatest_x - least_x;
	assign span_y_raw = greatest_y - least_y;
	assign span_x     = (span_x_raw == '0) ? SW'(1) : span_x_raw;
	assign span_y     = (span_y_raw == '0) ? SW'(1) : span_y_raw;

	// ---------------- shared multiplier and divider
	assign mul_a  = (state_q == S_MULY) ? diff_y : diff_x;
	assign mul_b  = (state_q == S_MULY) ? size_y : size_x;
	assign prod_d = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (state_q == S_MULX || state_q == S_MULY) prod_q <= prod_d;
	end

	assign div_start = (state_q == S_STX) || (state_q == S_STY);

	ppam_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.QW          (QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor ((state_q == S_STY) ? span_y : span_x),
		.quotient(quot),
		.stat    (div_stat)
	);

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (map_acc) state_q <= bad_index ? S_FIN : S_MULX;
				end
				S_MULX: state_q <= S_STX;
				S_STX:  state_q <= S_DIVX;
				S_DIVX: begin
					if (div_stat.done) state_q <= S_MULY;
				end
				S_MULY: state_q <= S_STY;
				S_STY:  state_q <= S_DIVY;
				S_DIVY: begin
					if (div_stat.done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working result registers
	always_ff @(posedge clk) begin
		if (map_acc) begin
			st_q  <= bad_index;
			col_q <= '0;
			row_q <= '0;
		end
		if (state_q == S_DIVX && div_stat.done) begin
			col_q <= area_left_q + quot[CW-1:0];
		end
		if (state_q == S_DIVY && div_stat.done) begin
			// ceiling: round up on a nonzero remainder
			row_q <= area_bottom_q[CW-1:0] - CW'(1) - quot[CW-1:0] - CW'(div_stat.rem_nz);
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			column_q  <= col_q;
			row_out_q <= row_q;
			status_q  <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign column    = column_q;
	assign row       = row_out_q;
	assign status    = status_q;

endmodule

// ----- src/ppam_checker.sv -----
// Port-level checker for the plot point autoscale mapper, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppam_checker #(
	parameter int COORD_WIDTH = ppam_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   op,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COORD_WIDTH-1:0] column,
	input logic [COORD_WIDTH-1:0] row,
	input logic                   status
);

	// a stalled result holds
	`PPAM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(column) && $stable(row) && $stable(status))

	// after a load the block is ready again in the next cycle
	`PPAM_ASSERT_NEXT(a_load_one_cycle, clk, arst_n, in_valid && in_ready && (op == ppam_pkg::OP_LOAD), in_ready)

	// a map request keeps the block busy
	`PPAM_ASSERT_NEXT(a_map_busy, clk, arst_n, in_valid && in_ready && (op == ppam_pkg::OP_MAP), !in_ready)

	// unloaded index reports zero position
	`PPAM_ASSERT_NOW(a_bad_zero, clk, arst_n, out_valid && status, (column == '0) && (row == '0))

endmodule

bind plot_point_autoscale_mapper_core ppam_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_ppam_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.op       (op),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.column   (column),
	.row      (row),
	.status   (status)
);

// ----- bench/ppam_mapper_monitor.sv -----
// Channel monitor for the point mapper: tracks the point set, predicts each mapped cell, checks results.
`timescale 1ns / 1ps
module ppam_mapper_monitor (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [1:0]                              cfg_index,
	input  logic [ppam_pkg::COORD_WIDTH_DEF:0]      cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic                                    op,
	input  logic                                    first,
	input  logic signed [ppam_pkg::SAMPLE_WIDTH_DEF-1:0] x_sample,
	input  logic signed [ppam_pkg::SAMPLE_WIDTH_DEF-1:0] y_sample,
	input  logic [ppam_pkg::INDEX_WIDTH-1:0]        point_index,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic [ppam_pkg::COORD_WIDTH_DEF-1:0]    column,
	input  logic [ppam_pkg::COORD_WIDTH_DEF-1:0]    row,
	input  logic                                    status,
	output int                                      mismatches,
	output int                                      cells_pending
);
	localparam int DEPTH = ppam_pkg::POINT_DEPTH_DEF;
	localparam int SW    = ppam_pkg::SAMPLE_WIDTH_DEF;
	localparam int CW    = ppam_pkg::COORD_WIDTH_DEF;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_UNLOADED = 1'b1;

	typedef struct packed {
		logic [CW-1:0] column;
		logic [CW-1:0] row;
		logic          status;
	} cell_t;

	logic signed [SW-1:0] x_pts [DEPTH];
	logic signed [SW-1:0] y_pts [DEPTH];
	int unsigned          n_pts;
	logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
	logic [CW-1:0]        left_edge, top_edge;
	logic [CW:0]          right_edge, bottom_edge;
	cell_t                cells_due [$];

	// far - near - 1, never below zero
	function automatic longint axis_extent(longint near_e, longint far_e);
		longint s;
		s = far_e - near_e - 1;
		return (s < 0) ? 0 : s;
	endfunction

	function automatic longint axis_range(longint lo, longint hi);
		return (hi == lo) ? 1 : hi - lo;
	endfunction

	function automatic cell_t map_to_cell(logic [ppam_pkg::INDEX_WIDTH-1:0] idx);
		cell_t  c;
		longint t, sp, off_x, off_y, col, rw;
		c = '0;
		if (idx >= n_pts) begin
			c.status = STATUS_UNLOADED;
			return c;
		end
		t = (longint'(x_pts[idx]) - longint'(lo_x)) * axis_extent(left_edge, right_edge);
		off_x = t / axis_range(lo_x, hi_x);
		sp = axis_range(lo_y, hi_y);
		t = (longint'(y_pts[idx]) - longint'(lo_y)) * axis_extent(top_edge, bottom_edge);
		// rows round away from the bottom edge
		off_y = t / sp + (((t % sp) != 0) ? 1 : 0);
		col = longint'(left_edge) + off_x;
		rw = longint'(bottom_edge) - 1 - off_y;
		c.column = col[CW-1:0];
		c.row = rw[CW-1:0];
		c.status = STATUS_OK;
		return c;
	endfunction

	task automatic take_point(logic first_f, logic signed [SW-1:0] xs, logic signed [SW-1:0] ys);
		if (first_f || n_pts == 0) begin
			n_pts = 0;
			lo_x = xs;
			hi_x = xs;
			lo_y = ys;
			hi_y = ys;
		end else if (n_pts >= DEPTH) begin
			return;
		end else begin
			if (xs < lo_x) lo_x = xs;
			if (xs > hi_x) hi_x = xs;
			if (ys < lo_y) lo_y = ys;
			if (ys > hi_y) hi_y = ys;
		end
		x_pts[n_pts] = xs;
		y_pts[n_pts] = ys;
		n_pts++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cell_t want;
		if (!arst_n) begin
			n_pts = 0;
			lo_x = '0;
			hi_x = '0;
			lo_y = '0;
			hi_y = '0;
			left_edge = CW'(ppam_pkg::AREA_LEFT_RST);
			top_edge = CW'(ppam_pkg::AREA_TOP_RST);
			right_edge = (CW + 1)'(ppam_pkg::AREA_RIGHT_RST);
			bottom_edge = (CW + 1)'(ppam_pkg::AREA_BOTTOM_RST);
			cells_due.delete();
			mismatches = 0;
			cells_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: column %0d row %0d status %0d",
						$time, column, row, status);
				end else begin
					want = cells_due.pop_front();
					if (want !== {column, row, status}) begin
						mismatches++;
						$display("%0t mismatch: expected column %0d row %0d status %0d, got column %0d row %0d status %0d",
							$time, want.column, want.row, want.status, column, row, status);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ppam_pkg::CFG_AREA_LEFT:   left_edge = cfg_data[CW-1:0];
					ppam_pkg::CFG_AREA_TOP:    top_edge = cfg_data[CW-1:0];
					ppam_pkg::CFG_AREA_RIGHT:  right_edge = cfg_data;
					ppam_pkg::CFG_AREA_BOTTOM: bottom_edge = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (op == ppam_pkg::OP_LOAD) take_point(first, x_sample, y_sample);
				else cells_due.push_back(map_to_cell(point_index));
			end
			cells_pending = cells_due.size();
		end
	end
endmodule

// ----- bench/plot_point_autoscale_mapper_core_test.sv -----
// Stimulus and verdict for the plot point autoscale mapper core.
`timescale 1ns / 1ps
module plot_point_autoscale_mapper_core_test;
	localparam int DEPTH = ppam_pkg::POINT_DEPTH_DEF;
	localparam int SW    = ppam_pkg::SAMPLE_WIDTH_DEF;
	localparam int CW    = ppam_pkg::COORD_WIDTH_DEF;
	localparam int IW    = ppam_pkg::INDEX_WIDTH;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int SEGMENT_ITEMS = 160;

	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};

	typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_EDGES} spread_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = '0;
	logic [CW:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = 1'b0;
	logic                 first = 1'b0;
	logic signed [SW-1:0] x_sample = '0;
	logic signed [SW-1:0] y_sample = '0;
	logic [IW-1:0]        point_index = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CW-1:0]        column;
	logic [CW-1:0]        row;
	logic                 status;
	int                   mismatches;
	int                   cells_pending;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned set_size = 0;
	int          items_sent = 0;

	plot_point_autoscale_mapper_core u_dut (.*);
	ppam_mapper_monitor u_monitor (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic offer(logic op_f, logic first_f, logic signed [SW-1:0] xs,
			logic signed [SW-1:0] ys, logic [IW-1:0] idx);
		bit took;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_f;
		first <= first_f;
		x_sample <= xs;
		y_sample <= ys;
		point_index <= idx;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	task automatic load_point(logic first_f, logic signed [SW-1:0] xs, logic signed [SW-1:0] ys);
		offer(ppam_pkg::OP_LOAD, first_f, xs, ys, IW'($urandom));
		if (first_f || set_size == 0) set_size = 1;
		else if (set_size < DEPTH) set_size++;
	endtask

	task automatic map_point(logic [IW-1:0] idx);
		offer(ppam_pkg::OP_MAP, 1'($urandom), SW'($urandom), SW'($urandom), idx);
	endtask

	task automatic write_reg(ppam_pkg::ppam_cfg_idx_t idx, int value);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (CW + 1)'(value);
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// waits out all outstanding map requests, then rewrites the plot area
	task automatic set_area(int l, int t, int r, int b);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (cells_pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ppam_pkg::CFG_AREA_LEFT, l);
		write_reg(ppam_pkg::CFG_AREA_TOP, t);
		write_reg(ppam_pkg::CFG_AREA_RIGHT, r);
		write_reg(ppam_pkg::CFG_AREA_BOTTOM, b);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] pick_sample(spread_t mode, logic signed [SW-1:0] base);
		case (mode)
			SPREAD_NARROW: return base + SW'($urandom_range(63)) - SW'(32);
			SPREAD_FLAT:   return base;
			SPREAD_EDGES:  return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
			default:       return SW'($urandom);
		endcase
	endfunction

	function automatic logic [IW-1:0] pick_index();
		if ($urandom_range(7) == 0) return IW'($urandom);
		return IW'($urandom_range(set_size - 1));
	endfunction

	task automatic run_set(bit fill);
		spread_t              sx, sy;
		logic signed [SW-1:0] bx, by;
		int                   n_loads;
		sx = spread_t'($urandom_range(3));
		sy = spread_t'($urandom_range(3));
		bx = SW'($urandom);
		by = SW'($urandom);
		if ($urandom_range(9) == 0 && !fill) begin
			// noise: loose requests of either kind
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(1)) load_point(1'($urandom), SW'($urandom), SW'($urandom));
				else map_point(IW'($urandom));
			end
			return;
		end
		n_loads = (fill || $urandom_range(39) == 0) ? $urandom_range(DEPTH, DEPTH + 4)
			: $urandom_range(1, 24);
		load_point($urandom_range(7) != 0, pick_sample(sx, bx), pick_sample(sy, by));
		for (int i = 1; i < n_loads; i++) begin
			// a stray set start now and then
			load_point($urandom_range(29) == 0, pick_sample(sx, bx), pick_sample(sy, by));
			if ($urandom_range(7) == 0) map_point(pick_index());
		end
		repeat ($urandom_range(1, 12)) map_point(pick_index());
	endtask

	initial begin
		int goal;
		int seg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, loads without a set start, extremes, zero span, rounding
		map_point(IW'(0));
		load_point(1'b0, SAMPLE_MIN, SAMPLE_MAX);
		load_point(1'b0, SAMPLE_MAX, SAMPLE_MIN);
		load_point(1'b0, SW'(0), SW'(0));
		map_point(IW'(0));
		map_point(IW'(1));
		map_point(IW'(2));
		map_point(IW'(3));
		map_point(IW'(255));
		load_point(1'b1, SW'(7), -SW'(7));
		map_point(IW'(0));
		map_point(IW'(1));
		load_point(1'b0, SW'(10), SW'(3));
		load_point(1'b0, SW'(3), SW'(10));
		map_point(IW'(1));
		map_point(IW'(2));
		map_point(IW'(0));

		goal = items_sent;
		seg = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (3) begin
				case (seg)
					0: set_area(ppam_pkg::AREA_LEFT_RST, ppam_pkg::AREA_TOP_RST,
						ppam_pkg::AREA_RIGHT_RST, ppam_pkg::AREA_BOTTOM_RST);
					1: set_area(0, 0, 4096, 4096);
					2: set_area(4095, 4095, 4096, 4096);
					3: set_area(4095, 4095, 1, 1);
					4: set_area(10, 5, 12, 7);
					default: set_area($urandom_range(4095), $urandom_range(4095),
						$urandom_range(1, 4096), $urandom_range(1, 4096));
				endcase
				// once offer a set of at least DEPTH loads to fill the store
				if (seg == 3) run_set(1'b1);
				// long result hold-off so the core backs up into its request side
				if (phase == 2 && seg == 6) hold_req = 1'b1;
				goal += SEGMENT_ITEMS;
				while (items_sent < goal) run_set(1'b0);
				seg++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (cells_pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("plot_point_autoscale_mapper_core_test: clean");
		end else begin
			$display("plot_point_autoscale_mapper_core_test: errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("plot_point_autoscale_mapper_core_test: errors");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/ppam_pkg.sv
src/ppam_store.sv
src/ppam_div.sv
src/plot_point_autoscale_mapper_core.sv
src/ppam_checker.sv
bench/ppam_mapper_monitor.sv
bench/plot_point_autoscale_mapper_core_test.sv
